// ----- hdl/lcdw_pkg.sv -----
// Shared types, codes and tables for the character LCD nibble write sequencer.
// Holds the microcode control word, its read-only program and the init command table.
// No dependencies; every other file of the block imports this package.
package lcdw_pkg;

  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int COL_W     = 6;
  localparam int NIB_W     = 4;
  localparam int PHASE_W   = 16;
  localparam int HOLD_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 3;
  localparam int CMD_IDX_W = 3;

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSTR = 3'd1;
  localparam logic [OP_W-1:0] OP_DATA  = 3'd2;
  localparam logic [OP_W-1:0] OP_POS   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_HOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_UP   = 2'd1;

  localparam logic [PHASE_W-1:0] PHASE_HOLD_RESET = 16'd3000;
  localparam logic [HOLD_W-1:0]  POWER_UP_RESET   = 20'd45000;

  localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'h01;
  localparam logic [BYTE_W-1:0] POS_BASE   = 8'h80;

  // Microprogram step addresses.
  localparam logic [STEP_W-1:0] STEP_POWER  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_HI_EH  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_HI_EL  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LO_EH  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LO_EL  = 3'd4;

  localparam logic [CMD_IDX_W-1:0] INIT_CMD_FIRST = 3'd0;
  localparam logic [CMD_IDX_W-1:0] INIT_CMD_LAST  = 3'd6;

  // One control word per microprogram step.
  typedef struct packed {
    logic              enable;     // E level of the phase
    logic              low_nib;    // present the low nibble instead of the high one
    logic              power_wait; // power-up wait phase: bus zero, power-up hold
    logic              end_check;  // end of a byte: loop to the next init command or finish
    logic [STEP_W-1:0] next_step;
  } ucw_t;

  // Pin state of one phase, before the last-phase mark is added.
  typedef struct packed {
    logic              rs;
    logic              enable;
    logic [NIB_W-1:0]  nibble;
    logic [HOLD_W-1:0] hold;
  } phase_t;

  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '0;
    unique case (step)
      STEP_POWER: begin
        w.power_wait = 1'b1;
        w.next_step  = STEP_HI_EH;
      end
      STEP_HI_EH: begin
        w.enable    = 1'b1;
        w.next_step = STEP_HI_EL;
      end
      STEP_HI_EL: begin
        w.next_step = STEP_LO_EH;
      end
      STEP_LO_EH: begin
        w.enable    = 1'b1;
        w.low_nib   = 1'b1;
        w.next_step = STEP_LO_EL;
      end
      STEP_LO_EL: begin
        w.low_nib   = 1'b1;
        w.end_check = 1'b1;
        w.next_step = STEP_HI_EH;
      end
      default: begin
        w.end_check = 1'b1;
        w.next_step = STEP_HI_EH;
      end
    endcase
    return w;
  endfunction

  function automatic logic [BYTE_W-1:0] init_cmd(input logic [CMD_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] c;
    unique case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h28;
      3'd3:    c = 8'h08;
      3'd4:    c = 8'h01;
      3'd5:    c = 8'h06;
      default: c = 8'h0F;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/lcdw_req_if.sv -----
// Request channel: valid/ready handshake carrying one LCD operation.
// Depends on lcdw_pkg for field widths.
interface lcdw_req_if;
  import lcdw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] byte_value;
  logic [COL_W-1:0]  column;
  logic              row;
  modport source (output valid, operation, byte_value, column, row, input ready);
  modport sink   (input valid, operation, byte_value, column, row, output ready);
endinterface

// ----- hdl/lcdw_phase_if.sv -----
// Phase channel: valid/ready handshake carrying one timed pin state.
// Depends on lcdw_pkg for field widths.
interface lcdw_phase_if;
  import lcdw_pkg::*;
  logic              valid;
  logic              ready;
  logic              register_select;
  logic              enable_level;
  logic [NIB_W-1:0]  bus_nibble;
  logic [HOLD_W-1:0] hold_ticks;
  logic              last_phase;
  modport source (output valid, register_select, enable_level, bus_nibble, hold_ticks,
                  last_phase, input ready);
  modport sink   (input valid, register_select, enable_level, bus_nibble, hold_ticks,
                  last_phase, output ready);
endinterface

// ----- hdl/lcdw_cfg_if.sv -----
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on lcdw_pkg for field widths.
interface lcdw_cfg_if;
  import lcdw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [HOLD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/lcdw_useq.sv -----
// Microcode sequencer: step counter, control word lookup and init command loop.
// Depends on lcdw_pkg for the control word type and the program table.
module lcdw_useq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           start_init,
  input  logic                           advance,
  output logic                           busy,
  output logic                           init_mode,
  output lcdw_pkg::ucw_t                 ucw,
  output logic [lcdw_pkg::CMD_IDX_W-1:0] cmd_idx,
  output logic                           last
);
  import lcdw_pkg::*;

  logic [STEP_W-1:0] step;
  logic              loop_back;

  assign ucw       = ucode_rom(step);
  assign loop_back = ucw.end_check && init_mode && (cmd_idx != INIT_CMD_LAST);
  assign last      = ucw.end_check && !loop_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      init_mode <= 1'b0;
      step      <= STEP_POWER;
      cmd_idx   <= INIT_CMD_FIRST;
    end else if (start) begin
      busy      <= 1'b1;
      init_mode <= start_init;
      step      <= start_init ? STEP_POWER : STEP_HI_EH;
      cmd_idx   <= INIT_CMD_FIRST;
    end else if (advance) begin
      if (last) begin
        busy <= 1'b0;
      end
      if (loop_back) begin
        cmd_idx <= cmd_idx + 1'b1;
      end
      step <= ucw.next_step;
    end
  end

endmodule

// ----- hdl/lcdw_datapath.sv -----
// Phase datapath: picks the byte, splits it into nibbles and selects the hold time.
// Depends on lcdw_pkg for the control word and phase types and the init command table.
module lcdw_datapath (
  input  lcdw_pkg::ucw_t                 ucw,
  input  logic                           init_mode,
  input  logic [lcdw_pkg::CMD_IDX_W-1:0] cmd_idx,
  input  logic [lcdw_pkg::BYTE_W-1:0]    byte_reg,
  input  logic                           rs_reg,
  input  logic [lcdw_pkg::PHASE_W-1:0]   phase_hold,
  input  logic [lcdw_pkg::HOLD_W-1:0]    power_up,
  output lcdw_pkg::phase_t               phase
);
  import lcdw_pkg::*;

  logic [BYTE_W-1:0] cur_byte;

  assign cur_byte = init_mode ? init_cmd(cmd_idx) : byte_reg;

  always_comb begin
    phase.rs     = init_mode ? 1'b0 : rs_reg;
    phase.enable = ucw.enable;
    if (ucw.power_wait) begin
      phase.nibble = '0;
      phase.hold   = power_up;
    end else begin
      phase.nibble = ucw.low_nib ? cur_byte[NIB_W-1:0] : cur_byte[BYTE_W-1:NIB_W];
      phase.hold   = {{(HOLD_W-PHASE_W){1'b0}}, phase_hold};
    end
  end

endmodule

// ----- hdl/char_lcd_nibble_write_sequencer.sv -----
// Character LCD 4-bit write sequencer. One request becomes a run of timed phases:
// four for a byte operation, twenty-nine for initialize, one phase per cycle while the
// phase output register is free. The request transaction sets the busy and step registers,
// from which the first phase is registered; busy clears as the final phase is registered,
// and the next request is taken after that, so a request never overlaps a run.
// Synchronous active-high reset sets hold 3000, power-up wait 45000, empties the output.
module char_lcd_nibble_write_sequencer (
  input  logic  clk,
  input  logic  rst,
  lcdw_req_if.sink     req,
  lcdw_phase_if.source phase,
  lcdw_cfg_if.sink     cfg
);
  import lcdw_pkg::*;

  // Configuration registers. Writes are always taken; indexes beyond the list are dropped.
  logic [PHASE_W-1:0] phase_hold;
  logic [HOLD_W-1:0]  power_up;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_hold <= PHASE_HOLD_RESET;
      power_up   <= POWER_UP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_PHASE_HOLD) begin
        phase_hold <= cfg.data[PHASE_W-1:0];
      end else if (cfg.index == REG_POWER_UP) begin
        power_up <= cfg.data;
      end
    end
  end

  // Sequencer and datapath signals.
  logic                 busy;
  logic                 init_mode;
  ucw_t                 ucw;
  logic [CMD_IDX_W-1:0] cmd_idx;
  logic                 last;
  logic                 start;
  logic                 start_init;
  logic                 advance;
  phase_t               cur_phase;

  // Latched byte and register-select level for the byte operations.
  logic [BYTE_W-1:0]    byte_reg;
  logic                 rs_reg;
  logic [BYTE_W-1:0]    pos_byte;

  logic                 req_fire;

  // A new request is taken whenever no run is in progress, even while the final phase
  // of the previous run still sits in the output register.
  assign req.ready = !busy;
  assign req_fire  = req.valid && req.ready;

  // Cursor address: 0x80 plus column plus 0x40 for the second line.
  assign pos_byte = POS_BASE + {{(BYTE_W-COL_W){1'b0}}, req.column}
                  + {1'b0, req.row, {(BYTE_W-2){1'b0}}};

  // Undefined operation codes start nothing and leave no trace.
  always_comb begin
    start      = 1'b0;
    start_init = 1'b0;
    if (req_fire) begin
      unique case (req.operation)
        OP_INIT: begin
          start      = 1'b1;
          start_init = 1'b1;
        end
        OP_INSTR, OP_DATA, OP_POS, OP_CLEAR: start = 1'b1;
        default: start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      unique case (req.operation)
        OP_INSTR: begin
          byte_reg <= req.byte_value;
          rs_reg   <= 1'b0;
        end
        OP_DATA: begin
          byte_reg <= req.byte_value;
          rs_reg   <= 1'b1;
        end
        OP_POS: begin
          byte_reg <= pos_byte;
          rs_reg   <= 1'b0;
        end
        OP_CLEAR: begin
          byte_reg <= CMD_CLEAR;
          rs_reg   <= 1'b0;
        end
        default: begin
          byte_reg <= byte_reg;
          rs_reg   <= rs_reg;
        end
      endcase
    end
  end

  // While a run is in progress, a step is issued whenever the output register is empty or is being emptied.
  assign advance = busy && (!phase.valid || phase.ready);

  lcdw_useq u_useq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_init (start_init),
    .advance    (advance),
    .busy       (busy),
    .init_mode  (init_mode),
    .ucw        (ucw),
    .cmd_idx    (cmd_idx),
    .last       (last)
  );

  lcdw_datapath u_datapath (
    .ucw        (ucw),
    .init_mode  (init_mode),
    .cmd_idx    (cmd_idx),
    .byte_reg   (byte_reg),
    .rs_reg     (rs_reg),
    .phase_hold (phase_hold),
    .power_up   (power_up),
    .phase      (cur_phase)
  );

  // Phase output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase.valid <= 1'b0;
    end else if (advance) begin
      phase.valid <= 1'b1;
    end else if (phase.ready) begin
      phase.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      phase.register_select <= cur_phase.rs;
      phase.enable_level    <= cur_phase.enable;
      phase.bus_nibble      <= cur_phase.nibble;
      phase.hold_ticks      <= cur_phase.hold;
      phase.last_phase      <= last;
    end
  end

endmodule
